// ===== rtl/dsia_pkg.sv =====
package dsia_pkg;

    localparam int TABLE_DEPTH = 512;
    localparam int COUNT_LIMIT = 1000;

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int FILL_W = $clog2(TABLE_DEPTH + 1);
    localparam int CNT_W  = $clog2(COUNT_LIMIT);
    localparam int DATE_W = 22;
    localparam int KEY_W  = DATE_W + 1;
    localparam int ID_W   = 31;
    localparam int STS_W  = 2;
    localparam int ENT_W  = KEY_W + CNT_W;

    localparam logic [13:0] YEAR_SCALE  = 14'd10000;
    localparam logic [6:0]  MONTH_SCALE = 7'd100;
    localparam logic [9:0]  ID_SCALE    = 10'd1000;

    localparam logic [STS_W-1:0] STS_OK        = 2'd0;
    localparam logic [STS_W-1:0] STS_COUNT_OVF = 2'd1;
    localparam logic [STS_W-1:0] STS_TABLE_FULL = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_KEY,
        S_SCAN,
        S_UPDATE,
        S_MUL,
        S_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic calc_key;
        logic scan;
        logic update;
        logic mul;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic scan_hit;
        logic scan_miss;
        logic out_busy;
    } t_sts;

endpackage

// ===== rtl/daily_sequence_id_allocator_top.sv =====
// channel  direction  handshake          payload
// request  in         i_valid / o_stall  i_id_kind, i_year_since_1900, i_month_num, i_day_num
// result   out        o_valid / i_stall  o_unique_id, o_status_code
//
// one request at a time; a request passes through these steps up to the result register
// (key, scan of the table ram at one entry per cycle with a registered read, update, multiply)
// reset empties the table at once through the fill count; no clearing pass
// a result held by i_stall does not block the next transfer; that request waits before output
module daily_sequence_id_allocator_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_id_kind,
    input  logic [7:0]                    i_year_since_1900,
    input  logic [3:0]                    i_month_num,
    input  logic [4:0]                    i_day_num,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [dsia_pkg::ID_W-1:0]     o_unique_id,
    output logic [dsia_pkg::STS_W-1:0]    o_status_code
);

    dsia_pkg::t_cmd cmd;
    dsia_pkg::t_sts sts;
    logic           in_rdy;

    dsia_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_sts    (sts),
        .o_cmd    (cmd),
        .o_in_rdy (in_rdy)
    );

    dsia_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_id_kind         (i_id_kind),
        .i_year_since_1900 (i_year_since_1900),
        .i_month_num       (i_month_num),
        .i_day_num         (i_day_num),
        .i_stall           (i_stall),
        .o_valid           (o_valid),
        .o_unique_id       (o_unique_id),
        .o_status_code     (o_status_code)
    );

    assign o_stall = !in_rdy;

endmodule

// ===== rtl/dsia_ram.sv =====
module dsia_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/dsia_ctrl.sv =====
module dsia_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  dsia_pkg::t_sts  i_sts,
    output dsia_pkg::t_cmd  o_cmd,
    output logic            o_in_rdy
);

    dsia_pkg::t_state r_state;
    dsia_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dsia_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state  = r_state;
        o_cmd    = '0;
        o_in_rdy = 1'b0;
        case (r_state)
            dsia_pkg::S_IDLE: begin
                o_in_rdy = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = dsia_pkg::S_KEY;
                end
            end
            dsia_pkg::S_KEY: begin
                o_cmd.calc_key = 1'b1;
                n_state        = dsia_pkg::S_SCAN;
            end
            dsia_pkg::S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_hit || i_sts.scan_miss) begin
                    n_state = dsia_pkg::S_UPDATE;
                end
            end
            dsia_pkg::S_UPDATE: begin
                o_cmd.update = 1'b1;
                n_state      = dsia_pkg::S_MUL;
            end
            dsia_pkg::S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = dsia_pkg::S_DONE;
            end
            dsia_pkg::S_DONE: begin
                if (!i_sts.out_busy) begin
                    o_cmd.finish = 1'b1;
                    n_state      = dsia_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dsia_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/dsia_dp.sv =====
module dsia_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  dsia_pkg::t_cmd                i_cmd,
    output dsia_pkg::t_sts                o_sts,
    input  logic                          i_id_kind,
    input  logic [7:0]                    i_year_since_1900,
    input  logic [3:0]                    i_month_num,
    input  logic [4:0]                    i_day_num,
    input  logic                          i_stall,
    output logic                          o_valid,
    output logic [dsia_pkg::ID_W-1:0]     o_unique_id,
    output logic [dsia_pkg::STS_W-1:0]    o_status_code
);

    logic                             r_kind;
    logic [7:0]                       r_year;
    logic [3:0]                       r_month;
    logic [4:0]                       r_day;
    logic [dsia_pkg::DATE_W-1:0]      r_date_key;
    logic [dsia_pkg::FILL_W-1:0]      r_fill;
    logic [dsia_pkg::FILL_W-1:0]      r_rd_idx;
    logic                             r_pend;
    logic [dsia_pkg::IDX_W-1:0]       r_pend_idx;
    logic                             r_hit;
    logic [dsia_pkg::IDX_W-1:0]       r_hit_idx;
    logic [dsia_pkg::CNT_W-1:0]       r_hit_cnt;
    logic [dsia_pkg::CNT_W-1:0]       r_cnt;
    logic [dsia_pkg::STS_W-1:0]       r_status;
    logic [dsia_pkg::ID_W-1:0]        r_prod;
    logic                             r_out_valid;
    logic [dsia_pkg::ID_W-1:0]        r_out_id;
    logic [dsia_pkg::STS_W-1:0]       r_out_status;

    logic [31:0]                      date_sum;
    logic [31:0]                      prod_full;
    logic [dsia_pkg::ENT_W-1:0]       rd_data;
    logic [dsia_pkg::KEY_W-1:0]       rd_key;
    logic [dsia_pkg::CNT_W-1:0]       rd_cnt;
    logic                             match;
    logic                             more;
    logic                             ram_re;
    logic                             ram_we;
    logic [dsia_pkg::IDX_W-1:0]       ram_waddr;
    logic [dsia_pkg::ENT_W-1:0]       ram_wdata;
    logic [dsia_pkg::CNT_W:0]         cnt_inc;
    logic                             is_full;

    assign date_sum = 32'(r_year) * 32'(dsia_pkg::YEAR_SCALE)
                    + 32'(r_month) * 32'(dsia_pkg::MONTH_SCALE)
                    + 32'(r_day);
    assign prod_full = 32'(r_date_key) * 32'(dsia_pkg::ID_SCALE);

    assign rd_key  = rd_data[dsia_pkg::ENT_W-1:dsia_pkg::CNT_W];
    assign rd_cnt  = rd_data[dsia_pkg::CNT_W-1:0];
    assign match   = r_pend && (rd_key == {r_date_key, r_kind});
    assign more    = r_rd_idx < r_fill;
    assign ram_re  = i_cmd.scan && !match && more;

    assign cnt_inc = {1'b0, r_hit_cnt} + {{dsia_pkg::CNT_W{1'b0}}, 1'b1};
    assign is_full = r_fill == dsia_pkg::FILL_W'(dsia_pkg::TABLE_DEPTH);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_hit_idx;
        ram_wdata = {r_date_key, r_kind, cnt_inc[dsia_pkg::CNT_W-1:0]};
        if (i_cmd.update) begin
            if (r_hit) begin
                ram_we = cnt_inc < (dsia_pkg::CNT_W + 1)'(dsia_pkg::COUNT_LIMIT);
            end else begin
                ram_we    = !is_full;
                ram_waddr = r_fill[dsia_pkg::IDX_W-1:0];
                ram_wdata = {r_date_key, r_kind, dsia_pkg::CNT_W'(1)};
            end
        end
    end

    dsia_ram #(
        .WIDTH (dsia_pkg::ENT_W),
        .DEPTH (dsia_pkg::TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_rd_idx[dsia_pkg::IDX_W-1:0]),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.calc_key) begin
                r_pend <= 1'b0;
            end
            if (i_cmd.scan) begin
                r_pend <= ram_re;
            end
            if (i_cmd.update && !r_hit && !is_full) begin
                r_fill <= r_fill + dsia_pkg::FILL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind  <= i_id_kind;
            r_year  <= i_year_since_1900;
            r_month <= i_month_num;
            r_day   <= i_day_num;
        end
        if (i_cmd.calc_key) begin
            r_date_key <= date_sum[dsia_pkg::DATE_W-1:0];
            r_rd_idx   <= '0;
        end
        if (i_cmd.scan) begin
            r_hit <= match;
            if (match) begin
                r_hit_idx <= r_pend_idx;
                r_hit_cnt <= rd_cnt;
            end else if (more) begin
                r_pend_idx <= r_rd_idx[dsia_pkg::IDX_W-1:0];
                r_rd_idx   <= r_rd_idx + dsia_pkg::FILL_W'(1);
            end
        end
        if (i_cmd.update) begin
            if (r_hit) begin
                r_cnt <= cnt_inc[dsia_pkg::CNT_W-1:0];
                if (cnt_inc < (dsia_pkg::CNT_W + 1)'(dsia_pkg::COUNT_LIMIT)) begin
                    r_status <= dsia_pkg::STS_OK;
                end else begin
                    r_status <= dsia_pkg::STS_COUNT_OVF;
                end
            end else begin
                r_cnt <= dsia_pkg::CNT_W'(1);
                if (is_full) begin
                    r_status <= dsia_pkg::STS_TABLE_FULL;
                end else begin
                    r_status <= dsia_pkg::STS_OK;
                end
            end
        end
        if (i_cmd.mul) begin
            r_prod <= prod_full[dsia_pkg::ID_W-1:0];
        end
        if (i_cmd.finish) begin
            r_out_status <= r_status;
            if (r_status == dsia_pkg::STS_OK) begin
                r_out_id <= r_prod + dsia_pkg::ID_W'(r_cnt);
            end else begin
                r_out_id <= '0;
            end
        end
    end

    assign o_sts.scan_hit  = match;
    assign o_sts.scan_miss = !match && !r_pend && !more;
    assign o_sts.out_busy  = r_out_valid && i_stall;

    assign o_valid       = r_out_valid;
    assign o_unique_id   = r_out_id;
    assign o_status_code = r_out_status;

endmodule
